### rtl/drp_pkg.sv
// drp_pkg: shared types, codes and constants for the discovery reply parser
// no dependencies; used by drp_parser and discovery_reply_parser_retry
`timescale 1ns / 1ps
`default_nettype none

package drp_pkg;

  localparam int unsigned MAX_DATAGRAM = 1024;
  localparam int unsigned BPOS_W = $clog2(MAX_DATAGRAM + 1);

  // commands
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_REQUEST = 2'd0;
  localparam logic [1:0] KIND_FOUND   = 2'd1;
  localparam logic [1:0] KIND_GAVE_UP = 2'd2;

  // fault codes
  localparam logic [2:0] FAULT_NONE    = 3'd0;
  localparam logic [2:0] FAULT_NOT_LOC = 3'd1;
  localparam logic [2:0] FAULT_IP      = 3'd2;
  localparam logic [2:0] FAULT_PORT    = 3'd3;
  localparam logic [2:0] FAULT_FORMAT  = 3'd4;
  localparam logic [2:0] FAULT_TIMEOUT = 3'd5;

  // configuration register indexes
  localparam logic [1:0] REG_MAX_ATTEMPTS  = 2'd0;
  localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd1;
  localparam logic [1:0] REG_DEST_IP       = 2'd2;
  localparam logic [1:0] REG_DEST_PORT     = 2'd3;

  // error flag bits
  localparam int unsigned FLB_NOTLOC = 0;
  localparam int unsigned FLB_IP     = 1;
  localparam int unsigned FLB_PORT   = 2;
  localparam int unsigned FLB_FMT    = 3;
  localparam int unsigned FLB_STOP   = 4;

  // port token modes
  localparam logic [1:0] PM_START  = 2'd0;
  localparam logic [1:0] PM_DIGITS = 2'd1;
  localparam logic [1:0] PM_DONE   = 2'd3;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [16:0] PORT_SAT = 17'h10000;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] rx_byte;
    logic       rx_last;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  fault;
    logic [31:0] addr;
    logic [15:0] udp_port;
    logic [7:0]  attempt;
  } out_t;

  typedef struct packed {
    logic [BPOS_W-1:0] byte_pos;
    logic [2:0]        token_idx;
    logic [1:0]        token_len;
    logic [7:0]        octet_acc;
    logic [1:0]        octet_digits;
    logic [1:0]        octet_count;
    logic [31:0]       ip_shift;
    logic [16:0]       port_acc;
    logic [1:0]        port_mode;
    logic [1:0]        end_match;
    logic [4:0]        flags;
  } parse_st_t;

  typedef struct packed {
    logic [2:0]  fault;
    logic [31:0] addr;
    logic [15:0] udp_port;
  } verdict_t;

  function automatic logic [7:0] loc_char(input logic [1:0] pos);
    logic [7:0] ch;
    case (pos)
      2'd0: ch = 8'h4c;
      2'd1: ch = 8'h4f;
      default: ch = 8'h43;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] end_char(input logic [1:0] pos);
    logic [7:0] ch;
    case (pos)
      2'd0: ch = 8'h45;
      2'd1: ch = 8'h4e;
      default: ch = 8'h44;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

### rtl/drp_parser.sv
// drp_parser: per-byte reply parsing step and end-of-datagram verdict
// depends on drp_pkg
`timescale 1ns / 1ps
`default_nettype none

module drp_parser (
  input  wire drp_pkg::parse_st_t pst,
  input  wire logic [7:0]         rx_byte,
  output drp_pkg::parse_st_t      pst_nxt,
  output drp_pkg::verdict_t       verdict
);

  drp_pkg::parse_st_t s_byte;
  drp_pkg::parse_st_t s_fin;

  function automatic drp_pkg::parse_st_t finish_token(input drp_pkg::parse_st_t s);
    drp_pkg::parse_st_t r;
    r = s;
    case (r.token_idx)
      3'd2: begin
        if (!r.flags[drp_pkg::FLB_IP]) begin
          if (r.octet_digits == 2'd0 || r.octet_count != 2'd3) begin
            r.flags[drp_pkg::FLB_IP] = 1'b1;
          end else begin
            r.ip_shift = {r.ip_shift[23:0], r.octet_acc};
          end
        end
      end
      3'd3: begin
        if (r.port_acc == 17'd0 || r.port_acc > 17'd65535) r.flags[drp_pkg::FLB_PORT] = 1'b1;
      end
      3'd4: begin
        if (r.end_match != 2'd3) r.flags[drp_pkg::FLB_FMT] = 1'b1;
      end
      default: ;
    endcase
    r.token_len = 2'd0;
    return r;
  endfunction

  function automatic drp_pkg::parse_st_t feed_token(input drp_pkg::parse_st_t s,
                                                    input logic [7:0] c);
    drp_pkg::parse_st_t r;
    logic               digit;
    logic [3:0]         d;
    logic [11:0]        ov;
    logic [19:0]        pv;
    r = s;
    digit = (c >= drp_pkg::CH_ZERO) && (c <= drp_pkg::CH_NINE);
    d = digit ? c[3:0] : 4'd0;
    ov = 12'(r.octet_acc) * 12'd10 + 12'(d);
    pv = 20'(r.port_acc) * 20'd10 + 20'(d);
    case (r.token_idx)
      3'd2: begin
        if (!r.flags[drp_pkg::FLB_IP]) begin
          if (digit) begin
            if ((r.octet_digits != 2'd0 && r.octet_acc == 8'd0) || ov > 12'd255) begin
              r.flags[drp_pkg::FLB_IP] = 1'b1;
            end else begin
              r.octet_acc = ov[7:0];
              if (r.octet_digits != 2'd3) r.octet_digits = r.octet_digits + 2'd1;
            end
          end else if (c == drp_pkg::CH_DOT && r.octet_digits != 2'd0
                       && r.octet_count != 2'd3) begin
            r.ip_shift = {r.ip_shift[23:0], r.octet_acc};
            r.octet_count = r.octet_count + 2'd1;
            r.octet_acc = 8'd0;
            r.octet_digits = 2'd0;
          end else begin
            r.flags[drp_pkg::FLB_IP] = 1'b1;
          end
        end
      end
      3'd3: begin
        if (r.port_mode == drp_pkg::PM_START) begin
          if (c >= drp_pkg::CH_TAB && c <= drp_pkg::CH_CR) begin
            r.port_mode = drp_pkg::PM_START;
          end else if (c == drp_pkg::CH_PLUS) begin
            r.port_mode = drp_pkg::PM_DIGITS;
          end else if (c == drp_pkg::CH_MINUS) begin
            r.flags[drp_pkg::FLB_PORT] = 1'b1;
            r.port_mode = drp_pkg::PM_DONE;
          end else if (digit) begin
            r.port_acc = 17'(d);
            r.port_mode = drp_pkg::PM_DIGITS;
          end else begin
            r.port_mode = drp_pkg::PM_DONE;
          end
        end else if (r.port_mode != drp_pkg::PM_DONE) begin
          if (digit) begin
            r.port_acc = (pv > 20'(drp_pkg::PORT_SAT)) ? drp_pkg::PORT_SAT : pv[16:0];
          end else begin
            r.port_mode = drp_pkg::PM_DONE;
          end
        end
      end
      3'd4: begin
        if (r.token_len != 2'd3 && c == drp_pkg::end_char(r.token_len)) begin
          r.end_match = r.end_match + 2'd1;
        end else begin
          r.flags[drp_pkg::FLB_FMT] = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always_comb begin
    s_byte = pst;
    if (pst.byte_pos < drp_pkg::BPOS_W'(drp_pkg::MAX_DATAGRAM)) begin
      if (!pst.flags[drp_pkg::FLB_STOP]) begin
        if (pst.byte_pos < drp_pkg::BPOS_W'(3) && rx_byte != drp_pkg::loc_char(pst.byte_pos[1:0]))
          s_byte.flags[drp_pkg::FLB_NOTLOC] = 1'b1;
        if (rx_byte == 8'd0) begin
          if (s_byte.token_len != 2'd0) s_byte = finish_token(s_byte);
          s_byte.flags[drp_pkg::FLB_STOP] = 1'b1;
        end else if (rx_byte == drp_pkg::CH_SPACE) begin
          if (s_byte.token_len != 2'd0) s_byte = finish_token(s_byte);
        end else begin
          if (s_byte.token_len == 2'd0) begin
            if (s_byte.token_idx >= 3'd4) s_byte.flags[drp_pkg::FLB_STOP] = 1'b1;
            else s_byte.token_idx = s_byte.token_idx + 3'd1;
          end
          if (!s_byte.flags[drp_pkg::FLB_STOP]) begin
            s_byte = feed_token(s_byte, rx_byte);
            if (s_byte.token_len != 2'd3) s_byte.token_len = s_byte.token_len + 2'd1;
          end
        end
      end
      s_byte.byte_pos = s_byte.byte_pos + drp_pkg::BPOS_W'(1);
    end
  end

  always_comb begin
    s_fin = s_byte;
    if (!s_byte.flags[drp_pkg::FLB_STOP] && s_byte.token_len != 2'd0) s_fin = finish_token(s_byte);
  end

  always_comb begin
    verdict.addr = s_fin.ip_shift;
    verdict.udp_port = s_fin.port_acc[15:0];
    if (s_fin.flags[drp_pkg::FLB_NOTLOC] || s_fin.byte_pos < drp_pkg::BPOS_W'(3)) begin
      verdict.fault = drp_pkg::FAULT_NOT_LOC;
    end else if (s_fin.token_idx < 3'd4 || s_fin.flags[drp_pkg::FLB_FMT]) begin
      verdict.fault = drp_pkg::FAULT_FORMAT;
    end else if (s_fin.flags[drp_pkg::FLB_IP]) begin
      verdict.fault = drp_pkg::FAULT_IP;
    end else if (s_fin.flags[drp_pkg::FLB_PORT]) begin
      verdict.fault = drp_pkg::FAULT_PORT;
    end else begin
      verdict.fault = drp_pkg::FAULT_NONE;
    end
  end

  assign pst_nxt = s_byte;

endmodule

`default_nettype wire

### rtl/discovery_reply_parser_retry.sv
// discovery_reply_parser_retry: discovery client with retry control and output stage
// depends on drp_pkg and drp_parser
// a result is registered in the output register, or in the skid entry if held
// throughput: one input item per cycle; one result may wait while the next item
// is taken, held in a two-entry output stage; input stalls only when both are full
// reset: synchronous, active low; control registers to their reset values, phase idle
`timescale 1ns / 1ps
`default_nettype none

module discovery_reply_parser_retry (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire drp_pkg::in_t in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output drp_pkg::out_t    out_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  typedef enum logic {PH_IDLE, PH_WAIT} phase_t;

  phase_t             phase_r, phase_nxt;
  logic [7:0]         attempts_r, attempts_nxt;
  logic [15:0]        wait_r, wait_nxt;
  drp_pkg::parse_st_t pst_r, pst_nxt;
  drp_pkg::parse_st_t pst_byte;
  drp_pkg::verdict_t  verdict;

  logic [7:0]  max_attempts_r;
  logic [15:0] timeout_ticks_r;
  logic [31:0] dest_ip_r;
  logic [15:0] dest_port_r;

  logic          out_valid_r, out_valid_nxt;
  drp_pkg::out_t out_data_r, out_data_nxt;
  logic          skid_valid_r, skid_valid_nxt;
  drp_pkg::out_t skid_data_r, skid_data_nxt;

  logic          accept;
  logic          pop;
  logic          res_v;
  drp_pkg::out_t res;
  logic [16:0]   wait_inc;
  logic [2:0]    fail_fault;
  logic          fail;

  drp_parser u_parser (
    .pst     (pst_r),
    .rx_byte (in_data.rx_byte),
    .pst_nxt (pst_byte),
    .verdict (verdict)
  );

  assign in_stall  = skid_valid_r;
  assign accept    = in_valid && !skid_valid_r;
  assign pop       = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign wait_inc  = 17'(wait_r) + 17'd1;

  // command handling
  always_comb begin
    phase_nxt = phase_r;
    attempts_nxt = attempts_r;
    wait_nxt = wait_r;
    pst_nxt = pst_r;
    res_v = 1'b0;
    res = '0;
    fail = 1'b0;
    fail_fault = drp_pkg::FAULT_NONE;
    if (accept) begin
      if (in_data.cmd == drp_pkg::CMD_START) begin
        wait_nxt = 16'd0;
        pst_nxt = '0;
        res_v = 1'b1;
        if (max_attempts_r == 8'd0) begin
          phase_nxt = PH_IDLE;
          attempts_nxt = 8'd0;
          res.kind = drp_pkg::KIND_GAVE_UP;
        end else begin
          phase_nxt = PH_WAIT;
          attempts_nxt = 8'd1;
          res.kind = drp_pkg::KIND_REQUEST;
          res.addr = dest_ip_r;
          res.udp_port = dest_port_r;
        end
        res.attempt = attempts_nxt;
      end else if (phase_r == PH_WAIT) begin
        case (in_data.cmd)
          drp_pkg::CMD_BYTE: begin
            pst_nxt = pst_byte;
            if (in_data.rx_last) begin
              if (verdict.fault == drp_pkg::FAULT_NONE) begin
                phase_nxt = PH_IDLE;
                pst_nxt = '0;
                res_v = 1'b1;
                res.kind = drp_pkg::KIND_FOUND;
                res.addr = verdict.addr;
                res.udp_port = verdict.udp_port;
                res.attempt = attempts_r;
              end else begin
                fail = 1'b1;
                fail_fault = verdict.fault;
              end
            end
          end
          drp_pkg::CMD_TICK: begin
            if (pst_r.byte_pos == '0 && timeout_ticks_r != 16'd0) begin
              wait_nxt = wait_inc[15:0];
              if (wait_inc >= 17'(timeout_ticks_r)) begin
                fail = 1'b1;
                fail_fault = drp_pkg::FAULT_TIMEOUT;
              end
            end
          end
          default: ;
        endcase
      end
    end
    if (fail) begin
      res_v = 1'b1;
      res.fault = fail_fault;
      pst_nxt = '0;
      if (attempts_r >= max_attempts_r) begin
        phase_nxt = PH_IDLE;
        res.kind = drp_pkg::KIND_GAVE_UP;
        res.attempt = attempts_r;
      end else begin
        phase_nxt = PH_WAIT;
        attempts_nxt = attempts_r + 8'd1;
        wait_nxt = 16'd0;
        res.kind = drp_pkg::KIND_REQUEST;
        res.addr = dest_ip_r;
        res.udp_port = dest_port_r;
        res.attempt = attempts_nxt;
      end
    end
  end

  // two-entry output stage
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt = skid_data_r;
    if (pop) begin
      if (skid_valid_r) begin
        out_data_nxt = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else if (res_v) begin
        out_data_nxt = res;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (!out_valid_r) begin
      if (res_v) begin
        out_valid_nxt = 1'b1;
        out_data_nxt = res;
      end
    end else if (res_v) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      attempts_r <= 8'd0;
      wait_r <= 16'd0;
      pst_r <= '0;
      out_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
      max_attempts_r <= 8'd3;
      timeout_ticks_r <= 16'd1000;
      dest_ip_r <= 32'hffff_ffff;
      dest_port_r <= 16'd0;
    end else begin
      phase_r <= phase_nxt;
      attempts_r <= attempts_nxt;
      wait_r <= wait_nxt;
      pst_r <= pst_nxt;
      out_valid_r <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          drp_pkg::REG_MAX_ATTEMPTS:  max_attempts_r <= cfg_data[7:0];
          drp_pkg::REG_TIMEOUT_TICKS: timeout_ticks_r <= cfg_data[15:0];
          drp_pkg::REG_DEST_IP:       dest_ip_r <= cfg_data;
          drp_pkg::REG_DEST_PORT:     dest_port_r <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

`ifndef SYNTHESIS
  a_skid_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without a head entry");

  a_request_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind == drp_pkg::KIND_REQUEST) |-> out_data.attempt != 8'd0)
    else $error("request transfer with zero attempt count");

  a_idle_parser_clear: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> pst_r.byte_pos == '0)
    else $error("parser state left over while idle");

  a_found_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind == drp_pkg::KIND_FOUND) |-> out_data.fault == drp_pkg::FAULT_NONE)
    else $error("found result carries a fault");
`endif

endmodule

`default_nettype wire

### verif/discovery_reply_parser_retry_tb.sv
// testbench for discovery_reply_parser_retry: directed and random commands and reply datagrams
// checks every result transfer against an in-bench prediction of the discovery client
// depends on drp_pkg and the discovery_reply_parser_retry rtl
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0]  CMD_UNUSED = 2'd3;
  localparam logic [23:0] LOC_WORD   = "LOC";
  localparam logic [23:0] END_WORD   = "END";

  typedef enum logic {ST_IDLE, ST_WAITING} client_phase_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  drp_pkg::in_t   in_data = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  drp_pkg::out_t  out_data;
  logic           cfg_we = 1'b0;
  logic [1:0]     cfg_index = '0;
  logic [31:0]    cfg_data = '0;

  discovery_reply_parser_retry dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predicted registers and client state
  logic [7:0]    cfg_max_attempts;
  logic [15:0]   cfg_timeout;
  logic [31:0]   cfg_dest_ip;
  logic [15:0]   cfg_dest_port;
  client_phase_t st_phase;
  logic [7:0]    st_attempts;
  logic [15:0]   st_wait;
  logic [10:0]   st_pos;
  logic [2:0]    st_tok_idx;
  logic [10:0]   st_tok_len;
  logic [9:0]    st_octet;
  logic [1:0]    st_digits;
  logic [2:0]    st_octets;
  logic [31:0]   st_ip;
  logic [16:0]   st_port;
  logic [1:0]    st_port_mode;
  logic [1:0]    st_end_match;
  logic [4:0]    st_flags;

  drp_pkg::out_t awaited_events[$];
  drp_pkg::in_t  pending_cmds[$];
  logic [7:0]    frame[$];
  int unsigned   work_items = 0;
  int unsigned   failures = 0;
  int unsigned   tx_idle_pct = 0;
  int unsigned   rx_idle_pct = 0;
  int unsigned   tx_gap = 0;
  int unsigned   rx_gap = 0;
  int unsigned   hold_cycles = 0;
  logic          hold_req = 1'b0;
  logic          in_taken = 1'b0;

  function automatic logic [7:0] char_of(logic [23:0] word, int unsigned p);
    return word[8*(2-p) +: 8];
  endfunction

  function automatic void clear_parse();
    st_pos = '0; st_tok_idx = '0; st_tok_len = '0;
    st_octet = '0; st_digits = '0; st_octets = '0; st_ip = '0;
    st_port = '0; st_port_mode = drp_pkg::PM_START; st_end_match = '0; st_flags = '0;
  endfunction

  function automatic void post_event(logic [1:0] kind, logic [2:0] fault, logic [31:0] addr,
                                     logic [15:0] port);
    drp_pkg::out_t ev;
    ev.kind = kind;
    ev.fault = fault;
    ev.addr = addr;
    ev.udp_port = port;
    ev.attempt = st_attempts;
    awaited_events.push_back(ev);
  endfunction

  function automatic void send_request(logic [2:0] fault);
    st_attempts++;
    st_phase = ST_WAITING;
    st_wait = '0;
    clear_parse();
    post_event(drp_pkg::KIND_REQUEST, fault, cfg_dest_ip, cfg_dest_port);
  endfunction

  function automatic void retry_or_quit(logic [2:0] fault);
    if (st_attempts >= cfg_max_attempts) begin
      st_phase = ST_IDLE;
      clear_parse();
      post_event(drp_pkg::KIND_GAVE_UP, fault, '0, '0);
    end else begin
      send_request(fault);
    end
  endfunction

  function automatic void feed_token(logic [7:0] c, logic [10:0] pos);
    logic        digit;
    int unsigned d;
    int unsigned v;
    digit = (c >= drp_pkg::CH_ZERO) && (c <= drp_pkg::CH_NINE);
    d = digit ? 32'(c - drp_pkg::CH_ZERO) : 0;
    if (st_tok_idx == 3'd2) begin
      if (st_flags[drp_pkg::FLB_IP]) return;
      if (digit) begin
        v = st_octet * 10 + d;
        if ((st_digits > 0 && st_octet == 0) || v > 255) begin
          st_flags[drp_pkg::FLB_IP] = 1'b1;
        end else begin
          st_octet = 10'(v);
          if (st_digits < 3) st_digits++;
        end
      end else if (c == drp_pkg::CH_DOT && st_digits > 0 && st_octets < 3) begin
        st_ip = {st_ip[23:0], st_octet[7:0]};
        st_octets++;
        st_octet = '0;
        st_digits = '0;
      end else begin
        st_flags[drp_pkg::FLB_IP] = 1'b1;
      end
    end else if (st_tok_idx == 3'd3) begin
      if (st_port_mode == drp_pkg::PM_DONE) return;
      if (st_port_mode == drp_pkg::PM_START) begin
        if (c >= drp_pkg::CH_TAB && c <= drp_pkg::CH_CR) return;
        if (c == drp_pkg::CH_PLUS) begin
          st_port_mode = drp_pkg::PM_DIGITS;
        end else if (c == drp_pkg::CH_MINUS) begin
          st_flags[drp_pkg::FLB_PORT] = 1'b1;
          st_port_mode = drp_pkg::PM_DONE;
        end else if (digit) begin
          st_port = 17'(d);
          st_port_mode = drp_pkg::PM_DIGITS;
        end else begin
          st_port_mode = drp_pkg::PM_DONE;
        end
      end else if (digit) begin
        v = st_port * 10 + d;
        st_port = (v > drp_pkg::PORT_SAT) ? drp_pkg::PORT_SAT : 17'(v);
      end else begin
        st_port_mode = drp_pkg::PM_DONE;
      end
    end else if (st_tok_idx == 3'd4) begin
      if (pos < 3 && c == char_of(END_WORD, pos)) st_end_match++;
      else st_flags[drp_pkg::FLB_FMT] = 1'b1;
    end
  endfunction

  function automatic void finish_token();
    if (st_tok_idx == 3'd2) begin
      if (!st_flags[drp_pkg::FLB_IP]) begin
        if (st_digits == 0 || st_octets != 3) st_flags[drp_pkg::FLB_IP] = 1'b1;
        else st_ip = {st_ip[23:0], st_octet[7:0]};
      end
    end else if (st_tok_idx == 3'd3) begin
      if (st_port == 0 || st_port > 17'd65535) st_flags[drp_pkg::FLB_PORT] = 1'b1;
    end else if (st_tok_idx == 3'd4) begin
      if (st_end_match != 2'd3) st_flags[drp_pkg::FLB_FMT] = 1'b1;
    end
    st_tok_len = '0;
  endfunction

  function automatic void parse_byte(logic [7:0] c);
    if (st_pos >= drp_pkg::MAX_DATAGRAM) return;
    if (!st_flags[drp_pkg::FLB_STOP]) begin
      if (st_pos < 3 && c != char_of(LOC_WORD, st_pos)) st_flags[drp_pkg::FLB_NOTLOC] = 1'b1;
      if (c == 8'h00) begin
        if (st_tok_len > 0) finish_token();
        st_flags[drp_pkg::FLB_STOP] = 1'b1;
      end else if (c == drp_pkg::CH_SPACE) begin
        if (st_tok_len > 0) finish_token();
      end else begin
        if (st_tok_len == 0) begin
          if (st_tok_idx >= 4) st_flags[drp_pkg::FLB_STOP] = 1'b1;
          else st_tok_idx++;
        end
        if (!st_flags[drp_pkg::FLB_STOP]) begin
          feed_token(c, st_tok_len);
          if (st_tok_len < 11'd2047) st_tok_len++;
        end
      end
    end
    st_pos++;
  endfunction

  function automatic void close_datagram();
    logic [31:0] found_ip;
    logic [15:0] found_port;
    if (!st_flags[drp_pkg::FLB_STOP] && st_tok_len > 0) finish_token();
    if (st_flags[drp_pkg::FLB_NOTLOC] || st_pos < 3) begin
      retry_or_quit(drp_pkg::FAULT_NOT_LOC);
    end else if (st_tok_idx < 4 || st_flags[drp_pkg::FLB_FMT]) begin
      retry_or_quit(drp_pkg::FAULT_FORMAT);
    end else if (st_flags[drp_pkg::FLB_IP]) begin
      retry_or_quit(drp_pkg::FAULT_IP);
    end else if (st_flags[drp_pkg::FLB_PORT]) begin
      retry_or_quit(drp_pkg::FAULT_PORT);
    end else begin
      found_ip = st_ip;
      found_port = st_port[15:0];
      st_phase = ST_IDLE;
      clear_parse();
      post_event(drp_pkg::KIND_FOUND, drp_pkg::FAULT_NONE, found_ip, found_port);
    end
  endfunction

  function automatic void discovery_step(drp_pkg::in_t it);
    if (it.cmd == drp_pkg::CMD_START) begin
      st_attempts = '0;
      st_wait = '0;
      clear_parse();
      if (cfg_max_attempts == 0) begin
        st_phase = ST_IDLE;
        post_event(drp_pkg::KIND_GAVE_UP, drp_pkg::FAULT_NONE, '0, '0);
      end else begin
        send_request(drp_pkg::FAULT_NONE);
      end
    end else if (st_phase == ST_WAITING) begin
      if (it.cmd == drp_pkg::CMD_BYTE) begin
        parse_byte(it.rx_byte);
        if (it.rx_last) close_datagram();
      end else if (it.cmd == drp_pkg::CMD_TICK) begin
        if (st_pos == 0 && cfg_timeout != 0) begin
          st_wait++;
          if (st_wait >= cfg_timeout) retry_or_quit(drp_pkg::FAULT_TIMEOUT);
        end
      end
    end
  endfunction

  function automatic int unsigned idle_len(int unsigned pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) < 7) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned pick_pct();
    case ($urandom_range(2))
      0: return 0;
      1: return 15;
      default: return 40;
    endcase
  endfunction

  // sender: transfer recorded at the rising edge, next item offered at the falling edge
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      in_taken = 1'b1;
      discovery_step(in_data);
    end
  end

  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      if (tx_gap > 0) begin
        in_valid <= 1'b0;
        tx_gap--;
      end else if (pending_cmds.size() != 0) begin
        in_data <= pending_cmds.pop_front();
        in_valid <= 1'b1;
        tx_gap = idle_len(tx_idle_pct);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_cycles = 150;
    end
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else if (rx_gap > 0) begin
      out_stall <= 1'b1;
      rx_gap--;
    end else begin
      rx_gap = idle_len(rx_idle_pct);
      out_stall <= (rx_gap != 0);
      if (rx_gap != 0) rx_gap--;
    end
  end

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      failures++;
      $display("%0t ns: %s expected %0h actual %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    drp_pkg::out_t ev;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_events.size() == 0) begin
        failures++;
        $display("%0t ns: result with none expected, actual %p", $time, out_data);
      end else begin
        ev = awaited_events.pop_front();
        check_field("kind", 32'(ev.kind), 32'(out_data.kind));
        check_field("fault", 32'(ev.fault), 32'(out_data.fault));
        check_field("addr", ev.addr, out_data.addr);
        check_field("udp_port", 32'(ev.udp_port), 32'(out_data.udp_port));
        check_field("attempt", 32'(ev.attempt), 32'(out_data.attempt));
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      drp_pkg::REG_MAX_ATTEMPTS:  cfg_max_attempts = value[7:0];
      drp_pkg::REG_TIMEOUT_TICKS: cfg_timeout = value[15:0];
      drp_pkg::REG_DEST_IP:       cfg_dest_ip = value;
      drp_pkg::REG_DEST_PORT:     cfg_dest_port = value[15:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [7:0] attempts, logic [15:0] ticks, logic [31:0] ip,
                            logic [15:0] port);
    write_reg(drp_pkg::REG_MAX_ATTEMPTS, 32'(attempts));
    write_reg(drp_pkg::REG_TIMEOUT_TICKS, 32'(ticks));
    write_reg(drp_pkg::REG_DEST_IP, ip);
    write_reg(drp_pkg::REG_DEST_PORT, 32'(port));
  endtask

  task automatic settle();
    int unsigned spins;
    spins = 0;
    while ((pending_cmds.size() != 0 || in_valid || awaited_events.size() != 0)
           && spins < 400000) begin
      @(posedge clk);
      spins++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic queue_cmd(logic [1:0] c);
    drp_pkg::in_t it;
    it.cmd = c;
    it.rx_byte = 8'($urandom_range(255));
    it.rx_last = 1'($urandom_range(1));
    pending_cmds.push_back(it);
    if (c != CMD_UNUSED) work_items++;
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) frame.push_back(s[i]);
  endtask

  task automatic add_gap();
    repeat ($urandom_range(1, 3)) frame.push_back(drp_pkg::CH_SPACE);
  endtask

  // frame bytes go out as one datagram, optionally with ticks mixed in
  task automatic queue_frame(int unsigned tick_pct);
    drp_pkg::in_t it;
    for (int i = 0; i < frame.size(); i++) begin
      if ($urandom_range(99) < tick_pct) queue_cmd(drp_pkg::CMD_TICK);
      it.cmd = drp_pkg::CMD_BYTE;
      it.rx_byte = frame[i];
      it.rx_last = (i == frame.size() - 1);
      pending_cmds.push_back(it);
      work_items++;
    end
    frame.delete();
  endtask

  task automatic reply_case(string s);
    queue_cmd(drp_pkg::CMD_START);
    add_text(s);
    queue_frame(0);
  endtask

  task automatic build_reply();
    int unsigned val;
    int unsigned pos;
    frame.delete();
    add_text("LOC");
    add_gap();
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0: add_text($sformatf("%0d.%0d.%0d", $urandom_range(255), $urandom_range(255),
                              $urandom_range(255)));
        1: add_text($sformatf("%0d.%0d.%0d.%0d", $urandom_range(255), $urandom_range(256, 999),
                              $urandom_range(255), $urandom_range(255)));
        2: add_text($sformatf("0%0d.1.2.3", $urandom_range(9)));
        default: add_text("1..2.3");
      endcase
    end else begin
      add_text($sformatf("%0d.%0d.%0d.%0d", $urandom_range(255), $urandom_range(255),
                         $urandom_range(255), $urandom_range(255)));
    end
    add_gap();
    case ($urandom_range(11))
      0: add_text("+");
      1: add_text("\t");
      2: add_text("-");
      default: ;
    endcase
    case ($urandom_range(9))
      0: val = 0;
      1: val = $urandom_range(65536, 99999999);
      default: val = $urandom_range(1, 65535);
    endcase
    add_text($sformatf("%0d", val));
    if ($urandom_range(9) == 0) add_text("x");
    add_gap();
    case ($urandom_range(11))
      0: add_text("EN");
      1: add_text("ENDE");
      2: ;
      default: add_text("END");
    endcase
    if ($urandom_range(6) == 0) begin
      add_gap();
      add_text("more");
    end
    if ($urandom_range(3) == 0) begin
      pos = $urandom_range(frame.size() - 1);
      case ($urandom_range(3))
        0: frame[pos] = 8'($urandom_range(255));
        1: frame[pos] = 8'h00;
        2: while (frame.size() > pos + 1) void'(frame.pop_back());
        default: frame[$urandom_range(2)] = 8'($urandom_range(255));
      endcase
    end
  endtask

  task automatic random_session();
    int unsigned top;
    if ($urandom_range(9) == 0) queue_cmd(CMD_UNUSED);
    if ($urandom_range(9) != 0) queue_cmd(drp_pkg::CMD_START);
    top = (cfg_timeout != 0 && cfg_timeout <= 6) ? cfg_timeout + 1 : 2;
    repeat ($urandom_range(1, 4)) begin
      repeat ($urandom_range(0, top)) queue_cmd(drp_pkg::CMD_TICK);
      if ($urandom_range(4) != 0) begin
        build_reply();
        queue_frame(($urandom_range(3) == 0) ? 20 : 0);
      end
    end
  endtask

  task automatic random_config();
    logic [7:0]  attempts;
    logic [15:0] ticks;
    logic [31:0] ip;
    logic [15:0] port;
    case ($urandom_range(4))
      0: attempts = 8'd0;
      1: attempts = 8'd255;
      2: attempts = 8'd1;
      default: attempts = 8'($urandom_range(2, 4));
    endcase
    case ($urandom_range(4))
      0: ticks = 16'd0;
      1: ticks = 16'hffff;
      default: ticks = 16'($urandom_range(1, 6));
    endcase
    case ($urandom_range(3))
      0: ip = '0;
      1: ip = '1;
      default: ip = $urandom;
    endcase
    case ($urandom_range(3))
      0: port = '0;
      1: port = '1;
      default: port = 16'($urandom_range(65535));
    endcase
    set_config(attempts, ticks, ip, port);
  endtask

  initial begin
    cfg_max_attempts = 8'd3;
    cfg_timeout = 16'd1000;
    cfg_dest_ip = 32'hffff_ffff;
    cfg_dest_port = 16'd0;
    st_phase = ST_IDLE;
    st_attempts = '0;
    st_wait = '0;
    clear_parse();

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // directed: reply parsing under reset settings, then the field extremes
    tx_idle_pct = 15;
    rx_idle_pct = 15;
    reply_case("LOC 192.168.1.10 8080 END");
    settle();
    set_config(8'd255, 16'hffff, 32'h0, 16'hffff);
    queue_cmd(drp_pkg::CMD_BYTE);
    queue_cmd(drp_pkg::CMD_TICK);
    queue_cmd(CMD_UNUSED);
    reply_case("LOC 0.0.0.0 +65535 END");
    reply_case("LOC  255.255.255.255   \t1 END extra tokens");
    reply_case("LOC 01.2.3.4 80 END");
    reply_case("LOC 256.1.1.1 80 END");
    reply_case("LOC 1.2.3 80 END");
    reply_case("LOC 1.2.3.4. 80 END");
    reply_case("LOC 1.2.3.4 -5 END");
    reply_case("LOC 1.2.3.4 0 END");
    reply_case("LOC 1.2.3.4 9999999 END");
    reply_case("LOC 1.2.3.4 443x END");
    reply_case("LOC 1.2.3.4 80 ENDX");
    reply_case("LOC 1.2.3.4 80");
    reply_case("LOX 1.2.3.4 80 END");
    reply_case("LOC 999.x -1 EN");
    reply_case("LO");
    queue_cmd(drp_pkg::CMD_START);
    add_text("LOC 10.0.0.1 7 END");
    frame.push_back(8'h00);
    add_text("zz");
    queue_frame(0);
    queue_cmd(drp_pkg::CMD_START);
    frame.push_back(8'h00);
    queue_frame(0);
    queue_cmd(drp_pkg::CMD_START);
    reply_case("LOC 172.16.0.1 53 END");
    settle();

    // retries, timeouts and giving up
    set_config(8'd2, 16'd2, 32'hffff_ffff, 16'd1234);
    queue_cmd(drp_pkg::CMD_START);
    repeat (4) queue_cmd(drp_pkg::CMD_TICK);
    queue_cmd(drp_pkg::CMD_START);
    add_text("LOC 1.2.3.4 5 END");
    queue_frame(100);
    queue_cmd(drp_pkg::CMD_START);
    add_text("LOC");
    queue_frame(0);
    add_text("xx");
    queue_frame(0);
    settle();
    write_reg(drp_pkg::REG_MAX_ATTEMPTS, 32'd0);
    queue_cmd(drp_pkg::CMD_START);
    queue_cmd(drp_pkg::CMD_TICK);
    settle();
    set_config(8'd1, 16'd0, 32'h0a00_0001, 16'd9);
    queue_cmd(drp_pkg::CMD_START);
    repeat (5) queue_cmd(drp_pkg::CMD_TICK);
    add_text("LOC 8.8.8.8 65535 END");
    queue_frame(0);
    settle();

    // back-pressure: receiver holds off while requests keep coming
    set_config(8'd3, 16'd4, 32'hc0a8_00ff, 16'd4000);
    tx_idle_pct = 0;
    hold_req = 1'b1;
    repeat (40) queue_cmd(drp_pkg::CMD_START);
    settle();

    while (work_items < 750) begin
      random_config();
      tx_idle_pct = pick_pct();
      rx_idle_pct = pick_pct();
      repeat ($urandom_range(2, 5)) random_session();
      settle();
    end

    if (awaited_events.size() != 0) begin
      failures++;
      $display("%0t ns: %0d expected results never arrived", $time, awaited_events.size());
    end
    if (failures == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("testbench NOT OK");
    $finish;
  end

endmodule

### files.f
rtl/drp_pkg.sv
rtl/drp_parser.sv
rtl/discovery_reply_parser_retry.sv
verif/discovery_reply_parser_retry_tb.sv
